/* rtl/sme_pkg.sv */
// Shared constants, codes and types of the stack machine executor.
package sme_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int AW        = $clog2(MEM_WORDS);
    localparam int SPW       = $clog2(MEM_WORDS + 1);

    // Instruction codes
    localparam logic [7:0] OP_POP   = 8'd0;
    localparam logic [7:0] OP_IPOP  = 8'd1;
    localparam logic [7:0] OP_PUSH  = 8'd2;
    localparam logic [7:0] OP_IPUSH = 8'd3;
    localparam logic [7:0] OP_PUSHI = 8'd4;
    localparam logic [7:0] OP_JMP   = 8'd5;
    localparam logic [7:0] OP_JNZ   = 8'd6;
    localparam logic [7:0] OP_CALL  = 8'd7;
    localparam logic [7:0] OP_RET   = 8'd8;
    localparam logic [7:0] OP_READ  = 8'd9;
    localparam logic [7:0] OP_WRITE = 8'd10;
    localparam logic [7:0] OP_ALU   = 8'd11;
    localparam logic [7:0] OP_RND   = 8'd12;
    localparam logic [7:0] OP_DUP   = 8'd13;
    localparam logic [7:0] OP_HALT  = 8'd99;

    // ALU selectors
    localparam logic [3:0] ALU_EQ  = 4'd0;
    localparam logic [3:0] ALU_NE  = 4'd1;
    localparam logic [3:0] ALU_GE  = 4'd2;
    localparam logic [3:0] ALU_LE  = 4'd3;
    localparam logic [3:0] ALU_GT  = 4'd4;
    localparam logic [3:0] ALU_LT  = 4'd5;
    localparam logic [3:0] ALU_OR  = 4'd6;
    localparam logic [3:0] ALU_XOR = 4'd7;
    localparam logic [3:0] ALU_AND = 4'd8;
    localparam logic [3:0] ALU_NOT = 4'd9;
    localparam logic [3:0] ALU_ADD = 4'd10;
    localparam logic [3:0] ALU_SUB = 4'd11;
    localparam logic [3:0] ALU_MUL = 4'd12;
    localparam logic [3:0] ALU_DIV = 4'd13;
    localparam logic [3:0] ALU_MOD = 4'd14;
    localparam logic [3:0] ALU_NEG = 4'd15;

    // Status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_UNDER   = 3'd1;
    localparam logic [2:0] STAT_OVER    = 3'd2;
    localparam logic [2:0] STAT_BADADR  = 3'd3;
    localparam logic [2:0] STAT_DIVZ    = 3'd4;
    localparam logic [2:0] STAT_HALT    = 3'd5;
    localparam logic [2:0] STAT_STOPPED = 3'd6;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CHK   = 7'b0000100,
        S_RDA   = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic        neg_q;
        logic        neg_r;
    } div_req_t;

endpackage

/* rtl/sme_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/sme_div.sv */
// Iterative signed divider, one quotient bit per cycle, shared by div, mod and rnd.
module sme_div import sme_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        nq_reg, nq_next;
    logic        nr_reg, nr_next;
    logic [32:0] r_sh;
    logic [33:0] diff;
    logic        ge;

    assign r_sh = {r_reg, q_reg[31]};
    assign diff = {1'b0, r_sh} - {2'b00, d_reg};
    assign ge   = !diff[33];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        nq_next   = nq_reg;
        nr_next   = nr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
            nq_next   = req.neg_q;
            nr_next   = req.neg_r;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, keep the difference if it fits
            r_next   = ge ? diff[31:0] : r_sh[31:0];
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        r_reg  <= r_next;
        d_reg  <= d_next;
        nq_reg <= nq_next;
        nr_reg <= nr_next;
    end

    assign done      = done_reg;
    assign quotient  = nq_reg ? (32'd0 - q_reg) : q_reg;
    assign remainder = nr_reg ? (32'd0 - r_reg) : r_reg;

endmodule

/* rtl/stack_machine_executor_core.sv */
// Top level of the stack machine executor: sequencer, state registers and memory.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall   | opcode, operand, read_value, random_value
//  out     | output    | out_valid / out_stall | next_pc, write_valid, write_value, status
//
// After reset the word memory is cleared one word a cycle, all MEM_WORDS (4096) words,
// with in_stall high until the clear is done and the first word can be taken.
// A normal instruction holds in_stall high through its steps: check, first read,
// execute with second read data, result, return to idle; this pace is set by the
// single read port of the memory with its registered output.
// div, mod and rnd also wait in the shared bit-serial divider; errors found by the
// first check skip the read and execute steps and go straight to the result.
// A stalled result holds in its registers; no new word is taken until it leaves.
module stack_machine_executor_core import sme_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         opcode,
    input  logic signed [15:0] operand,
    input  logic signed [31:0] read_value,
    input  logic [30:0]        random_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        next_pc,
    output logic               write_valid,
    output logic signed [31:0] write_value,
    output logic [2:0]         status
);

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic [15:0]     pc_reg, pc_next;
    logic            stopped_reg, stopped_next;
    logic [7:0]      op_reg;
    logic [15:0]     opnd_reg;
    logic [31:0]     rdv_reg;
    logic [30:0]     rnv_reg;
    logic [31:0]     a_reg, a_next;
    logic            wv_reg, wv_next;
    logic [31:0]     wval_reg, wval_next;
    logic [2:0]      stat_reg, stat_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [31:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;

    div_req_t        div_req;
    logic            div_done;
    logic [31:0]     div_q;
    logic [31:0]     div_r;

    logic            accept;
    logic [AW-1:0]   sp_idx, spm1, spm2, opnd_idx;
    logic            full, sp_zero, sp_lt2, opnd_ok, rd_ok;
    logic            alu_sel_ok, alu_unary;
    logic [31:0]     opnd_sx;
    logic [16:0]     rnd_mag;
    logic [31:0]     bw_mag, tw_mag;
    logic [31:0]     alu_res;

    sme_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    sme_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);

    assign sp_idx   = sp_reg[AW-1:0];
    assign spm1     = AW'(sp_reg - SPW'(1));
    assign spm2     = AW'(sp_reg - SPW'(2));
    assign opnd_idx = opnd_reg[AW-1:0];
    assign full     = (sp_reg == SPW'(MEM_WORDS));
    assign sp_zero  = (sp_reg == '0);
    assign sp_lt2   = (sp_reg < SPW'(2));
    assign opnd_ok  = !opnd_reg[15] && (32'(opnd_reg[14:0]) < 32'(MEM_WORDS));
    assign rd_ok    = !ram_rdata[31] && (32'(ram_rdata[30:0]) < 32'(MEM_WORDS));
    assign opnd_sx  = {{16{opnd_reg[15]}}, opnd_reg};

    // selector range 0..15; not and neg act on the top word alone
    assign alu_sel_ok = (opnd_reg[15:4] == '0);
    assign alu_unary  = (opnd_reg[3:0] == ALU_NOT) || (opnd_reg[3:0] == ALU_NEG);

    // divider operands: rnd takes the magnitude of the operand
    assign rnd_mag = opnd_reg[15] ? (17'd0 - {1'b1, opnd_reg}) : {1'b0, opnd_reg};
    assign bw_mag  = ram_rdata[31] ? (32'd0 - ram_rdata) : ram_rdata;
    assign tw_mag  = a_reg[31] ? (32'd0 - a_reg) : a_reg;

    // two-operand result: next-to-top (read data) op top (a_reg)
    always_comb
    begin
        case (opnd_reg[3:0])
            ALU_EQ:  alu_res = {31'd0, ram_rdata == a_reg};
            ALU_NE:  alu_res = {31'd0, ram_rdata != a_reg};
            ALU_GE:  alu_res = {31'd0, $signed(ram_rdata) >= $signed(a_reg)};
            ALU_LE:  alu_res = {31'd0, $signed(ram_rdata) <= $signed(a_reg)};
            ALU_GT:  alu_res = {31'd0, $signed(ram_rdata) > $signed(a_reg)};
            ALU_LT:  alu_res = {31'd0, $signed(ram_rdata) < $signed(a_reg)};
            ALU_OR:  alu_res = ram_rdata | a_reg;
            ALU_XOR: alu_res = ram_rdata ^ a_reg;
            ALU_AND: alu_res = ram_rdata & a_reg;
            ALU_ADD: alu_res = ram_rdata + a_reg;
            ALU_SUB: alu_res = ram_rdata - a_reg;
            ALU_MUL: alu_res = ram_rdata * a_reg;
            default: alu_res = '0;
        endcase
    end

    always_comb
    begin
        logic [2:0]      chk;
        logic [15:0]     ex_pc;
        logic [SPW-1:0]  ex_sp;
        logic            ex_we;
        logic [AW-1:0]   ex_waddr;
        logic [31:0]     ex_wdata;
        logic            ex_div;
        logic            ex_divz;

        state_next   = state_reg;
        clr_next     = clr_reg;
        sp_next      = sp_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        a_next       = a_reg;
        wv_next      = wv_reg;
        wval_next    = wval_reg;
        stat_next    = stat_reg;
        ram_we       = 1'b0;
        ram_waddr    = sp_idx;
        ram_wdata    = a_reg;
        ram_raddr    = spm1;
        chk          = STAT_OK;
        ex_pc        = pc_reg;
        ex_sp        = sp_reg;
        ex_we        = 1'b0;
        ex_waddr     = sp_idx;
        ex_wdata     = a_reg;
        ex_div       = 1'b0;
        ex_divz      = 1'b0;

        div_req.start = 1'b0;
        if (op_reg == OP_RND)
        begin
            div_req.dividend = {1'b0, rnv_reg};
            div_req.divisor  = 32'(rnd_mag);
            div_req.neg_q    = 1'b0;
            div_req.neg_r    = 1'b0;
        end
        else
        begin
            div_req.dividend = bw_mag;
            div_req.divisor  = tw_mag;
            div_req.neg_q    = ram_rdata[31] ^ a_reg[31];
            div_req.neg_r    = ram_rdata[31];
        end

        case (state_reg)
            S_CLEAR:
            begin
                // zero one word a cycle
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MEM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                // stack bounds first, then direct address, then zero modulus
                case (op_reg)
                    OP_POP:   chk = sp_zero ? STAT_UNDER : (!opnd_ok ? STAT_BADADR : STAT_OK);
                    OP_IPOP:  chk = sp_lt2 ? STAT_UNDER : STAT_OK;
                    OP_PUSH:  chk = full ? STAT_OVER : (!opnd_ok ? STAT_BADADR : STAT_OK);
                    OP_IPUSH: chk = full ? STAT_OVER : (sp_zero ? STAT_UNDER : STAT_OK);
                    OP_PUSHI: chk = full ? STAT_OVER : STAT_OK;
                    OP_JNZ:   chk = sp_zero ? STAT_UNDER : STAT_OK;
                    OP_CALL:  chk = full ? STAT_OVER : STAT_OK;
                    OP_RET:   chk = sp_zero ? STAT_UNDER : STAT_OK;
                    OP_READ:  chk = !opnd_ok ? STAT_BADADR : STAT_OK;
                    OP_WRITE: chk = !opnd_ok ? STAT_BADADR : STAT_OK;
                    OP_ALU:
                    begin
                        if (alu_sel_ok && alu_unary && sp_zero)
                        begin
                            chk = STAT_UNDER;
                        end
                        else if (alu_sel_ok && !alu_unary && sp_lt2)
                        begin
                            chk = STAT_UNDER;
                        end
                    end
                    OP_RND:   chk = full ? STAT_OVER :
                                    ((opnd_reg == '0) ? STAT_DIVZ : STAT_OK);
                    OP_DUP:   chk = full ? STAT_OVER : (sp_zero ? STAT_UNDER : STAT_OK);
                    OP_HALT:  chk = STAT_HALT;
                    default:  chk = STAT_OK;
                endcase
                if (stopped_reg)
                begin
                    chk = STAT_STOPPED;
                end

                // first read: direct address or top of stack
                ram_raddr = ((op_reg == OP_PUSH) || (op_reg == OP_WRITE)) ? opnd_idx : spm1;
                wv_next   = 1'b0;
                wval_next = '0;
                stat_next = chk;
                if (chk != STAT_OK)
                begin
                    stopped_next = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_RDA;
                end
            end

            S_RDA:
            begin
                // hold the first word; ipush reads through it, ipop later writes through it
                a_next    = ram_rdata;
                ram_raddr = (op_reg == OP_IPUSH) ? ram_rdata[AW-1:0] : spm2;
                if (((op_reg == OP_IPOP) || (op_reg == OP_IPUSH)) && !rd_ok)
                begin
                    stat_next    = STAT_BADADR;
                    stopped_next = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (op_reg)
                    OP_POP:
                    begin
                        ex_we    = 1'b1;
                        ex_waddr = opnd_idx;
                        ex_sp    = sp_reg - SPW'(1);
                    end
                    OP_IPOP:
                    begin
                        ex_we    = 1'b1;
                        ex_waddr = a_reg[AW-1:0];
                        ex_wdata = ram_rdata;
                        ex_sp    = sp_reg - SPW'(2);
                    end
                    OP_PUSH:
                    begin
                        ex_we = 1'b1;
                        ex_sp = sp_reg + SPW'(1);
                    end
                    OP_IPUSH:
                    begin
                        ex_we    = 1'b1;
                        ex_waddr = spm1;
                        ex_wdata = ram_rdata;
                    end
                    OP_PUSHI:
                    begin
                        ex_we    = 1'b1;
                        ex_wdata = opnd_sx;
                        ex_sp    = sp_reg + SPW'(1);
                    end
                    OP_JMP:
                    begin
                        ex_pc = pc_reg + opnd_reg;
                    end
                    OP_JNZ:
                    begin
                        ex_sp = sp_reg - SPW'(1);
                        if (a_reg != '0)
                        begin
                            ex_pc = pc_reg + opnd_reg;
                        end
                    end
                    OP_CALL:
                    begin
                        ex_we    = 1'b1;
                        ex_wdata = {16'd0, pc_reg};
                        ex_sp    = sp_reg + SPW'(1);
                        ex_pc    = pc_reg + opnd_reg;
                    end
                    OP_RET:
                    begin
                        ex_pc = a_reg[15:0];
                        ex_sp = sp_reg - SPW'(1);
                    end
                    OP_READ:
                    begin
                        ex_we    = 1'b1;
                        ex_waddr = opnd_idx;
                        ex_wdata = rdv_reg;
                    end
                    OP_WRITE:
                    begin
                        wv_next   = 1'b1;
                        wval_next = a_reg;
                    end
                    OP_ALU:
                    begin
                        if (alu_sel_ok)
                        begin
                            case (opnd_reg[3:0])
                                ALU_NOT:
                                begin
                                    ex_we    = 1'b1;
                                    ex_waddr = spm1;
                                    ex_wdata = ~a_reg;
                                end
                                ALU_NEG:
                                begin
                                    ex_we    = 1'b1;
                                    ex_waddr = spm1;
                                    ex_wdata = 32'd0 - a_reg;
                                end
                                ALU_DIV, ALU_MOD:
                                begin
                                    if (a_reg == '0)
                                    begin
                                        ex_divz = 1'b1;
                                    end
                                    else
                                    begin
                                        ex_div = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    ex_we    = 1'b1;
                                    ex_waddr = spm2;
                                    ex_wdata = alu_res;
                                    ex_sp    = sp_reg - SPW'(1);
                                end
                            endcase
                        end
                    end
                    OP_RND:
                    begin
                        ex_div = 1'b1;
                    end
                    OP_DUP:
                    begin
                        ex_we = 1'b1;
                        ex_sp = sp_reg + SPW'(1);
                    end
                    default:
                    begin
                        ex_we = 1'b0;
                    end
                endcase

                if (ex_divz)
                begin
                    stat_next    = STAT_DIVZ;
                    stopped_next = 1'b1;
                    state_next   = S_OUT;
                end
                else if (ex_div)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    ram_we     = ex_we;
                    ram_waddr  = ex_waddr;
                    ram_wdata  = ex_wdata;
                    sp_next    = ex_sp;
                    pc_next    = ex_pc + 16'd1;
                    stat_next  = STAT_OK;
                    state_next = S_OUT;
                end
            end

            S_DIV:
            begin
                // wait for the divider, then commit like any other op
                if (div_done)
                begin
                    ram_we = 1'b1;
                    if (op_reg == OP_RND)
                    begin
                        ram_waddr = sp_idx;
                        ram_wdata = div_r;
                        sp_next   = sp_reg + SPW'(1);
                    end
                    else
                    begin
                        ram_waddr = spm2;
                        ram_wdata = (opnd_reg[3:0] == ALU_DIV) ? div_q : div_r;
                        sp_next   = sp_reg - SPW'(1);
                    end
                    pc_next    = pc_reg + 16'd1;
                    stat_next  = STAT_OK;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            sp_reg      <= '0;
            pc_reg      <= 16'd1;
            stopped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            sp_reg      <= sp_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
        end
    end

    // payload: capture the word on acceptance, hold results until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            opnd_reg <= operand;
            rdv_reg  <= read_value;
            rnv_reg  <= random_value;
        end
        a_reg    <= a_next;
        wv_reg   <= wv_next;
        wval_reg <= wval_next;
        stat_reg <= stat_next;
    end

    assign next_pc     = pc_reg;
    assign write_valid = wv_reg;
    assign write_value = wval_reg;
    assign status      = stat_reg;

endmodule
